// ===== rtl/sts_pkg.sv =====
// Shared types and constants for the sorted timestep schedule.
// Used by sorted_timestep_schedule; no dependencies.
package sts_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int STEP_W      = 31;
    localparam int ADDR_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int COUNT_OUT_W = 5;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(LIST_DEPTH);

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_MATCH = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef struct packed {
        action_t           action;
        logic [STEP_W-1:0] step_value;
    } sts_req_t;

    typedef struct packed {
        logic                   matched;
        logic                   overflow;
        logic [COUNT_OUT_W-1:0] entry_count;
    } sts_rsp_t;

endpackage

// ===== rtl/sts_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sorted_timestep_schedule.sv =====
// Sorted timestep schedule: sequencer around one shared step comparator and the list RAM.
// Depends on sts_pkg and sts_ram.
//
//   channel | signals                | dir | word
//   --------+------------------------+-----+-----------------------------------
//   req     | req_valid/req_stall    | in  | sts_req_t  {action, step_value}
//   rsp     | rsp_valid/rsp_stall    | out | sts_rsp_t  {matched, overflow, entry_count}
//
// One request at a time; req_stall is high from acceptance until its word is handed to the
// response register. Each list entry looked at takes a RAM read (S_RD), then a compare in
// the shared comparator (S_CMP); a walk that runs past the bottom entry ends in S_RD, and a
// match that does so empties the list. An add that inserts moves the entries at and above
// its place up one place each (S_SH_RD, S_SH_WR), then writes the new step; clear and no-op
// go straight to S_FIN.
// Reset clears the count and the sequencer; list contents are not cleared (never read
// beyond the count). A stalled response holds; the next request may be accepted meanwhile.
module sorted_timestep_schedule (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sts_pkg::sts_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sts_pkg::sts_rsp_t rsp
);

    localparam int AW = sts_pkg::ADDR_W;
    localparam int CW = sts_pkg::CNT_W;
    localparam int SW = sts_pkg::STEP_W;
    localparam int OW = sts_pkg::COUNT_OUT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FIN
    } state_t;

    state_t             state_reg, state_next;
    sts_pkg::action_t   act_reg, act_next;
    logic [SW-1:0]      val_reg, val_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               hit_reg, hit_next;
    logic               ovf_reg, ovf_next;
    logic               rsp_valid_reg, rsp_valid_next;
    sts_pkg::sts_rsp_t  rsp_reg, rsp_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [SW-1:0]      ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [SW-1:0]      ram_rdata;

    logic               step_eq;
    logic               step_lt;

    sts_ram #(
        .WIDTH (SW),
        .DEPTH (sts_pkg::LIST_DEPTH)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the shared comparator: request step against the entry just read
    assign step_eq = (val_reg == ram_rdata);
    assign step_lt = (val_reg < ram_rdata);

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        val_next       = val_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        ovf_next       = ovf_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(pos_reg);
        ram_wdata      = val_reg;
        ram_raddr      = AW'(k_reg - CW'(1));

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    val_next = req.step_value;
                    k_next   = cnt_reg;
                    hit_next = 1'b0;
                    ovf_next = 1'b0;
                    case (req.action)
                        sts_pkg::ACT_ADD,
                        sts_pkg::ACT_MATCH:
                        begin
                            state_next = S_RD;
                        end
                        sts_pkg::ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (k_reg == '0)
                begin
                    if (act_reg == sts_pkg::ACT_MATCH)
                    begin
                        cnt_next   = '0;
                        state_next = S_FIN;
                    end
                    else if (cnt_reg == sts_pkg::FULL_COUNT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        pos_next   = '0;
                        k_next     = cnt_reg;
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (act_reg == sts_pkg::ACT_MATCH)
                begin
                    if (step_eq || step_lt)
                    begin
                        hit_next   = step_eq;
                        cnt_next   = k_reg;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        k_next     = k_reg - CW'(1);
                        state_next = S_RD;
                    end
                end
                else if (step_eq)
                begin
                    // duplicate: list untouched
                    state_next = S_FIN;
                end
                else if (step_lt)
                begin
                    if (cnt_reg == sts_pkg::FULL_COUNT)
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        pos_next   = k_reg;
                        k_next     = cnt_reg;
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    k_next     = k_reg - CW'(1);
                    state_next = S_RD;
                end
            end

            S_SH_RD:
            begin
                if (k_reg == pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = AW'(pos_reg);
                    ram_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SH_WR;
                end
            end

            S_SH_WR:
            begin
                // move entry k-1 up one place
                ram_we     = 1'b1;
                ram_waddr  = AW'(k_reg);
                ram_wdata  = ram_rdata;
                k_next     = k_reg - CW'(1);
                state_next = S_SH_RD;
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.matched     = hit_reg;
                    rsp_next.overflow    = ovf_reg;
                    rsp_next.entry_count = OW'(cnt_reg);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            act_reg       <= sts_pkg::ACT_NONE;
            val_reg       <= '0;
            k_reg         <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            hit_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            act_reg       <= act_next;
            val_reg       <= val_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            hit_reg       <= hit_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sts_pkg::FULL_COUNT)
        else $error("list count above depth");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) <= cnt_reg))
        else $error("list write beyond count");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.matched && rsp.overflow))
        else $error("matched and overflow both set");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !(rsp_valid_reg && rsp_stall))
        |=> (rsp_valid_reg && rsp_reg.entry_count == OW'($past(cnt_reg))))
        else $error("response word count mismatch");

endmodule

// ===== tb/sorted_timestep_schedule_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sorted_timestep_schedule: directed and random add, match,
// clear and no-op words, with the predicted schedule held in a scoreboard class.
// Depends on sts_pkg and the sorted_timestep_schedule RTL.
module sorted_timestep_schedule_test;

    localparam int LIST_DEPTH  = sts_pkg::LIST_DEPTH;
    localparam int STEP_W      = sts_pkg::STEP_W;
    localparam int COUNT_OUT_W = sts_pkg::COUNT_OUT_W;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 4 * LIST_DEPTH + 16;
    localparam int RAND_PER_PH = 400;

    class schedule_scoreboard;
        logic [STEP_W-1:0]  steps[$];      // ascending; front is the top of the schedule
        sts_pkg::sts_rsp_t  expected_q[$];
        int unsigned        errors  = 0;
        int unsigned        n_rsp   = 0;
        int unsigned        n_add   = 0;
        int unsigned        n_drop  = 0;
        int unsigned        n_match = 0;
        int unsigned        n_hit   = 0;
        int unsigned        n_clear = 0;
        int unsigned        n_noop  = 0;

        function void note_request(sts_pkg::sts_req_t word);
            sts_pkg::sts_rsp_t want;
            int                pos;
            bit                dup;
            want = '0;
            case (word.action)
                sts_pkg::ACT_ADD:
                begin
                    n_add++;
                    pos = 0;
                    while (pos < steps.size() && steps[pos] < word.step_value)
                        pos++;
                    dup = (pos < steps.size()) && (steps[pos] == word.step_value);
                    if (!dup)
                    begin
                        if (steps.size() >= LIST_DEPTH)
                        begin
                            want.overflow = 1'b1;
                            n_drop++;
                        end
                        else
                            steps.insert(pos, word.step_value);
                    end
                end
                sts_pkg::ACT_MATCH:
                begin
                    n_match++;
                    // pop everything older than the step, an equal top stays put
                    while (steps.size() > 0 && steps[0] < word.step_value)
                        steps.delete(0);
                    if (steps.size() > 0 && steps[0] == word.step_value)
                    begin
                        want.matched = 1'b1;
                        n_hit++;
                    end
                end
                sts_pkg::ACT_CLEAR:
                begin
                    n_clear++;
                    steps.delete();
                end
                default:
                    n_noop++;
            endcase
            want.entry_count = COUNT_OUT_W'(steps.size());
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("ERROR %0t ns, response %0d: %s got %0h expected %0h",
                     $time, n_rsp, what, got, want);
        endtask

        task check_response(sts_pkg::sts_rsp_t got);
            sts_pkg::sts_rsp_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected word", 32'(got), 32'd0);
                return;
            end
            want = expected_q.pop_front();
            n_rsp++;
            if (got.matched !== want.matched)
                report_mismatch("matched", 32'(got.matched), 32'(want.matched));
            if (got.overflow !== want.overflow)
                report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    sts_pkg::sts_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    sts_pkg::sts_rsp_t rsp;

    int unsigned        send_idle_pct = 0;
    int unsigned        stall_pct     = 0;
    int unsigned        quiet_cycles  = 0;
    schedule_scoreboard sb            = new();

    sorted_timestep_schedule u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note_request(req);
            if (rsp_valid && !rsp_stall)
                sb.check_response(rsp);
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("FAIL sorted_timestep_schedule");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge where the word is taken, valid left high.
    task automatic send_request(input sts_pkg::action_t act, input logic [STEP_W-1:0] value);
        sts_pkg::sts_req_t word;
        word.action     = act;
        word.step_value = value;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= word;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    initial
    begin
        sts_pkg::action_t  act;
        logic [STEP_W-1:0] value;
        logic [STEP_W-1:0] now;
        int                r;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        now       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 64; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 64; end
                default: begin send_idle_pct = 7;  stall_pct = 7;  end
            endcase

            if (ph == 0)
            begin
                // extremes, duplicate, hit on top
                send_request(sts_pkg::ACT_ADD, '0);
                send_request(sts_pkg::ACT_ADD, '1);
                send_request(sts_pkg::ACT_ADD, '0);
                send_request(sts_pkg::ACT_MATCH, '0);
                // fill to the brim, out of order
                for (int k = 0; k < 14; k++)
                    send_request(sts_pkg::ACT_ADD, STEP_W'(((k * 5) % 14 + 1) * 10));
                // new step to a full list is dropped, a duplicate is not flagged
                send_request(sts_pkg::ACT_ADD, STEP_W'(5));
                send_request(sts_pkg::ACT_ADD, '1);
                // pops several, then stops at a larger top
                send_request(sts_pkg::ACT_MATCH, STEP_W'(45));
                send_request(sts_pkg::ACT_MATCH, STEP_W'(50));
                send_request(sts_pkg::ACT_CLEAR, STEP_W'(50));
                send_request(sts_pkg::ACT_MATCH, STEP_W'(5));
                send_request(sts_pkg::ACT_NONE, STEP_W'(123));
            end

            // Mostly a moving window of near-future steps, so that matches hit and the
            // list fills; the rest are wide values, clears and no-ops.
            for (int i = 0; i < RAND_PER_PH; i++)
            begin
                r = $urandom_range(99);
                if (r < 45)
                begin
                    act   = sts_pkg::ACT_ADD;
                    value = now + STEP_W'($urandom_range(24));
                end
                else if (r < 80)
                begin
                    act   = sts_pkg::ACT_MATCH;
                    now   = now + STEP_W'($urandom_range(6));
                    value = now;
                end
                else if (r < 84)
                begin
                    act   = sts_pkg::ACT_CLEAR;
                    value = STEP_W'($urandom);
                    now   = ($urandom_range(1) != 0) ? STEP_W'($urandom) : '0;
                end
                else if (r < 87)
                begin
                    act   = sts_pkg::ACT_NONE;
                    value = STEP_W'($urandom);
                end
                else if (r < 95)
                begin
                    act   = sts_pkg::ACT_ADD;
                    value = STEP_W'($urandom);
                end
                else
                begin
                    act   = sts_pkg::ACT_MATCH;
                    value = STEP_W'($urandom);
                end
                send_request(act, value);
            end
        end

        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d responses over four idle/stall phases", sb.n_rsp);
        $display("adds %0d (dropped %0d), matches %0d (hits %0d), clears %0d, no-ops %0d",
                 sb.n_add, sb.n_drop, sb.n_match, sb.n_hit, sb.n_clear, sb.n_noop);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS sorted_timestep_schedule");
        else
            $display("FAIL sorted_timestep_schedule");
        $finish;
    end
endmodule
